// ----- rtl/core/sph_pkg.sv -----
// shared types, constants and the control store of the siphash-2-4 engine
// no dependencies; used by sph_round and siphash_2_4_engine
package sph_pkg;

    localparam int LANE_W      = 64;
    localparam int STEP_W      = 3;
    localparam int CFG_INDEX_W = 2;

    localparam logic [LANE_W-1:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [LANE_W-1:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [LANE_W-1:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [LANE_W-1:0] SIP_C3 = 64'h7465646279746573;
    localparam logic [LANE_W-1:0] FINAL_FLIP = 64'h00000000000000ff;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 2'd1;

    localparam logic [7:0] FULL_WORD_BYTES = 8'd8;

    localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_WORD2  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_BLOCK1 = 3'd2;
    localparam logic [STEP_W-1:0] STEP_BLOCK2 = 3'd3;
    localparam logic [STEP_W-1:0] STEP_FIN1   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_FIN2   = 3'd5;
    localparam logic [STEP_W-1:0] STEP_FIN3   = 3'd6;
    localparam logic [STEP_W-1:0] STEP_FIN4   = 3'd7;

    typedef struct packed {
        logic [LANE_W-1:0] a;
        logic [LANE_W-1:0] b;
        logic [LANE_W-1:0] c;
        logic [LANE_W-1:0] d;
    } lanes_t;

    typedef enum logic [1:0] {
        MSG_NONE  = 2'd0,
        MSG_WORD  = 2'd1,
        MSG_BLOCK = 2'd2,
        MSG_FIRST = 2'd3
    } msg_sel_t;

    typedef enum logic [1:0] {
        COND_NONE  = 2'd0,
        COND_START = 2'd1,
        COND_MORE  = 2'd2,
        COND_EMIT  = 2'd3
    } cond_t;

    typedef struct packed {
        msg_sel_t          pre_sel;
        msg_sel_t          post_sel;
        logic              flip_c;
        cond_t             cond;
        logic [STEP_W-1:0] jump;
    } ctrl_t;

    // every step runs one round; pre xor into d, post xor into a
    localparam ctrl_t UCODE [8] = '{
        '{MSG_FIRST, MSG_NONE,  1'b0, COND_START, STEP_BLOCK2},
        '{MSG_NONE,  MSG_WORD,  1'b0, COND_MORE,  STEP_IDLE},
        '{MSG_BLOCK, MSG_NONE,  1'b0, COND_NONE,  STEP_IDLE},
        '{MSG_NONE,  MSG_BLOCK, 1'b1, COND_NONE,  STEP_IDLE},
        '{MSG_NONE,  MSG_NONE,  1'b0, COND_NONE,  STEP_IDLE},
        '{MSG_NONE,  MSG_NONE,  1'b0, COND_NONE,  STEP_IDLE},
        '{MSG_NONE,  MSG_NONE,  1'b0, COND_NONE,  STEP_IDLE},
        '{MSG_NONE,  MSG_NONE,  1'b0, COND_EMIT,  STEP_IDLE}
    };

    function automatic lanes_t sip_init(input logic [LANE_W-1:0] k0,
                                        input logic [LANE_W-1:0] k1);
        lanes_t l;
        l.a = k0 ^ SIP_C0;
        l.b = k1 ^ SIP_C1;
        l.c = k0 ^ SIP_C2;
        l.d = k1 ^ SIP_C3;
        return l;
    endfunction

endpackage

// ----- rtl/core/siphash_2_4_engine.sv -----
// top level of the keyed siphash-2-4 engine with a 64-bit hash
// depends on sph_pkg and sph_round
//
// Messages arrive as little-endian 64-bit words, the last one marked and
// carrying 0 to 8 bytes. One round unit runs one SipRound per cycle unless
// stalled on input or output, stepped by an eight-entry control store. A
// word that is not last is taken in the word-end step. A last word of 0 to
// 7 bytes skips from idle to the second block step, one of 8 bytes runs all
// steps; it is taken, and the hash loaded into the output register, on the
// final round, which waits while an earlier hash is still held there.
// Writing either key reloads the lanes and drops any message under way.
module siphash_2_4_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [63:0]                       message_word,
    input  logic [3:0]                        byte_count,
    input  logic                              last_word,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [63:0]                       hash_value,
    input  logic                              cfg_write,
    input  logic [sph_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [63:0]                       cfg_data
);
    import sph_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    lanes_t            lanes_reg, lanes_next;
    logic [7:0]        length_reg, length_next;
    logic [LANE_W-1:0] key_low_reg, key_low_next;
    logic [LANE_W-1:0] key_high_reg, key_high_next;
    logic              out_valid_reg, out_valid_next;
    logic [LANE_W-1:0] hash_reg, hash_next;

    ctrl_t             ctrl;
    logic              full_word;
    logic [3:0]        count_sat;
    logic [7:0]        length_final;
    logic [LANE_W-1:0] tail;
    logic [LANE_W-1:0] block_word;
    logic [LANE_W-1:0] pre_msg;
    logic [LANE_W-1:0] post_msg;
    lanes_t            round_in;
    lanes_t            round_out;
    lanes_t            lanes_post;
    logic              go;
    logic              accept;
    logic              emit;
    logic              key_write;
    logic              out_free;
    logic [STEP_W-1:0] step_inc;

    sph_round u_round (
        .lanes_in  (round_in),
        .lanes_out (round_out)
    );

    always_comb
    begin
        ctrl      = UCODE[step_reg];
        full_word = !last_word || byte_count[3];
        count_sat = byte_count[3] ? 4'd8 : byte_count;
        length_final = length_reg + (last_word ? {4'b0, count_sat} : FULL_WORD_BYTES);
        tail = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (!byte_count[3] && (4'(i) < byte_count))
            begin
                tail[8*i +: 8] = message_word[8*i +: 8];
            end
        end
        block_word = {length_final, tail[55:0]};

        case (ctrl.pre_sel)
            MSG_NONE:  pre_msg = '0;
            MSG_WORD:  pre_msg = message_word;
            MSG_BLOCK: pre_msg = block_word;
            MSG_FIRST: pre_msg = full_word ? message_word : block_word;
            default:   pre_msg = '0;
        endcase

        case (ctrl.post_sel)
            MSG_WORD:  post_msg = message_word;
            MSG_BLOCK: post_msg = block_word;
            default:   post_msg = '0;
        endcase

        round_in     = lanes_reg;
        round_in.d   = lanes_reg.d ^ pre_msg;
        lanes_post   = round_out;
        lanes_post.a = round_out.a ^ post_msg;
        lanes_post.c = round_out.c ^ (ctrl.flip_c ? FINAL_FLIP : '0);
    end

    assign out_free = !out_valid_reg || out_ready;
    assign step_inc = step_reg + 1'b1;

    always_comb
    begin
        go        = 1'b1;
        accept    = 1'b0;
        emit      = 1'b0;
        step_next = step_reg;
        case (ctrl.cond)
            COND_NONE:
            begin
                step_next = step_inc;
            end
            COND_START:
            begin
                go        = in_valid;
                step_next = in_valid ? (full_word ? step_inc : ctrl.jump) : step_reg;
            end
            COND_MORE:
            begin
                accept    = !last_word;
                step_next = last_word ? step_inc : ctrl.jump;
            end
            COND_EMIT:
            begin
                go        = out_free;
                accept    = out_free;
                emit      = out_free;
                step_next = out_free ? ctrl.jump : step_reg;
            end
            default:
            begin
                step_next = STEP_IDLE;
            end
        endcase
    end

    assign key_write = cfg_write && (cfg_index == REG_KEY_LOW || cfg_index == REG_KEY_HIGH);

    always_comb
    begin
        key_low_next   = key_low_reg;
        key_high_next  = key_high_reg;
        lanes_next     = lanes_reg;
        length_next    = length_reg;
        out_valid_next = out_valid_reg && !out_ready;
        hash_next      = hash_reg;
        if (key_write)
        begin
            if (cfg_index == REG_KEY_LOW)
            begin
                key_low_next = cfg_data;
            end
            else
            begin
                key_high_next = cfg_data;
            end
            lanes_next  = sip_init(key_low_next, key_high_next);
            length_next = '0;
        end
        else if (go)
        begin
            lanes_next = lanes_post;
            if (emit)
            begin
                lanes_next     = sip_init(key_low_reg, key_high_reg);
                length_next    = '0;
                out_valid_next = 1'b1;
                hash_next      = lanes_post.a ^ lanes_post.b ^ lanes_post.c ^ lanes_post.d;
            end
            else if (accept)
            begin
                length_next = length_reg + FULL_WORD_BYTES;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_IDLE;
            lanes_reg     <= sip_init('0, '0);
            length_reg    <= '0;
            key_low_reg   <= '0;
            key_high_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= key_write ? STEP_IDLE : step_next;
            lanes_reg     <= lanes_next;
            length_reg    <= length_next;
            key_low_reg   <= key_low_next;
            key_high_reg  <= key_high_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg <= hash_next;
    end

    assign in_ready   = accept;
    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

    // transfers only happen at the word end or on the final round
    a_ready_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (step_reg == STEP_WORD2 || step_reg == STEP_FIN4))
        else $error("input transfer outside a closing step");

    // a new hash only appears after the final round
    a_emit_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(step_reg == STEP_FIN4))
        else $error("hash loaded outside the final round");

    // after any input transfer the sequencer is back at idle
    a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (step_reg == STEP_IDLE))
        else $error("sequencer not idle after transfer");

    // the final round never overwrites a hash that is still held
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_FIN4 && out_valid && !out_ready) |=> $stable(hash_value))
        else $error("held hash overwritten");

endmodule

// ----- rtl/core/sph_round.sv -----
// one sipround over the four lanes, combinational
// depends on sph_pkg
module sph_round (
    input  sph_pkg::lanes_t lanes_in,
    output sph_pkg::lanes_t lanes_out
);
    import sph_pkg::*;

    logic [LANE_W-1:0] a1, a2, a3;
    logic [LANE_W-1:0] b0r, b1, b1r, b2;
    logic [LANE_W-1:0] c1, c2, c3;
    logic [LANE_W-1:0] d0r, d1, d1r, d2;

    always_comb
    begin
        a1  = lanes_in.a + lanes_in.b;
        b0r = {lanes_in.b[50:0], lanes_in.b[63:51]};
        b1  = b0r ^ a1;
        a2  = {a1[31:0], a1[63:32]};
        c1  = lanes_in.c + lanes_in.d;
        d0r = {lanes_in.d[47:0], lanes_in.d[63:48]};
        d1  = d0r ^ c1;
        a3  = a2 + d1;
        d1r = {d1[42:0], d1[63:43]};
        d2  = d1r ^ a3;
        c2  = c1 + b1;
        b1r = {b1[46:0], b1[63:47]};
        b2  = b1r ^ c2;
        c3  = {c2[31:0], c2[63:32]};
        lanes_out.a = a3;
        lanes_out.b = b2;
        lanes_out.c = c3;
        lanes_out.d = d2;
    end

endmodule
